/* design/permutation_unrank_core_assert.svh */
// Assertion macros shared by the permutation unrank RTL
`ifndef PERMUTATION_UNRANK_CORE_ASSERT_SVH
`define PERMUTATION_UNRANK_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define PU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define PU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/perm_pkg.sv */
// Package: widths, sequencer states and saturated factorial for permutation unrank
`timescale 1ns / 1ps

package perm_pkg;

  localparam int SET_W   = 4;
  localparam int RANK_W  = 29;
  localparam int ELEM_W  = 4;
  // one bit over the rank so 2^RANK_W (saturation value) fits
  localparam int FACT_W  = RANK_W + 1;
  localparam int MAX_SET_DEF = 12;

  localparam logic [FACT_W-1:0] FACT_SAT = FACT_W'(64'd1 << RANK_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DEC,
    ST_DIV,
    ST_PICK,
    ST_ERR
  } state_t;

  // Factorial clamped at 2^RANK_W; any clamped value exceeds every rank
  function automatic logic [FACT_W-1:0] fact_sat(input int n);
    longint p;
    p = 1;
    for (int j = 1; j <= n; j++) begin
      p = p * j;
      if (p > longint'(FACT_SAT)) p = longint'(FACT_SAT);
    end
    return FACT_W'(p);
  endfunction

endpackage

/* design/perm_if.sv */
// Request and result channel interfaces for permutation unrank
`timescale 1ns / 1ps

interface perm_in_if;
  logic                          valid;
  logic                          ready;
  logic [perm_pkg::SET_W-1:0]    set_size;
  logic [perm_pkg::RANK_W-1:0]   rank;

  modport source (output valid, set_size, rank, input ready);
  modport sink   (input valid, set_size, rank, output ready);
endinterface

interface perm_out_if;
  logic                          valid;
  logic                          ready;
  logic [perm_pkg::ELEM_W-1:0]   element;
  logic                          last;
  logic                          error;

  modport source (output valid, element, last, error, input ready);
  modport sink   (input valid, element, last, error, output ready);
endinterface

/* design/perm_sub.sv */
// Shared subtract/compare unit: difference and borrow of two factorial-width values
`timescale 1ns / 1ps

module perm_sub (
  input  logic [perm_pkg::FACT_W-1:0] a,
  input  logic [perm_pkg::FACT_W-1:0] b,
  output logic [perm_pkg::FACT_W-1:0] diff,
  output logic                        borrow
);

  // borrow set when b > a
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

/* design/permutation_unrank_core.sv */
// Each factorial-base digit is found by repeated subtraction in one shared subtractor,
// one subtraction per cycle; the element pick and list shift follow in their own state.
// Bad size: error straight from idle; bad rank (zero or above n!): from the check or decrement state.
// One request in flight; the result register lets the next request enter while it waits.
// Reset (rst, synchronous) returns the sequencer to idle and drops the result valid.
`timescale 1ns / 1ps
`include "permutation_unrank_core_assert.svh"

module permutation_unrank_core #(
  parameter int MAX_SET = perm_pkg::MAX_SET_DEF
) (
  input  logic             clk,
  input  logic             rst,
  perm_in_if.sink          req,
  perm_out_if.source       res
);

  localparam int CW = $clog2(MAX_SET + 1);
  localparam int IW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;

  perm_pkg::state_t state, state_next;

  logic [perm_pkg::RANK_W-1:0] k;
  logic [CW-1:0]               remaining;
  logic [CW-1:0]               idx;
  logic [perm_pkg::ELEM_W-1:0] pool [MAX_SET];

  logic                        out_valid;
  logic [perm_pkg::ELEM_W-1:0] out_elem;
  logic                        out_last;
  logic                        out_err;

  logic [perm_pkg::FACT_W-1:0] fact_tbl [MAX_SET + 1];
  logic [perm_pkg::FACT_W-1:0] sub_a, sub_b, sub_diff;
  logic                        sub_borrow;
  logic                        req_acc, out_free, size_bad;

  // Saturated factorial table, elaborated as constants
  for (genvar g = 0; g <= MAX_SET; g++) begin : g_fact
    assign fact_tbl[g] = perm_pkg::fact_sat(g);
  end

  perm_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  assign req.ready = (state == perm_pkg::ST_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;
  assign size_bad  = (req.set_size == '0) ||
                     ({1'b0, req.set_size} > (perm_pkg::SET_W + 1)'(MAX_SET));

  assign res.valid   = out_valid;
  assign res.element = out_elem;
  assign res.last    = out_last;
  assign res.error   = out_err;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      perm_pkg::ST_IDLE:  if (req_acc) state_next = size_bad ? perm_pkg::ST_ERR
                                                             : perm_pkg::ST_CHECK;
      perm_pkg::ST_CHECK: state_next = sub_borrow ? perm_pkg::ST_ERR : perm_pkg::ST_DEC;
      perm_pkg::ST_DEC:   state_next = sub_borrow ? perm_pkg::ST_ERR : perm_pkg::ST_DIV;
      perm_pkg::ST_DIV:   if (sub_borrow) state_next = perm_pkg::ST_PICK;
      perm_pkg::ST_PICK: begin
        if (out_free) state_next = (remaining == CW'(1)) ? perm_pkg::ST_IDLE
                                                         : perm_pkg::ST_DIV;
      end
      perm_pkg::ST_ERR:   if (out_free) state_next = perm_pkg::ST_IDLE;
      default:            state_next = perm_pkg::ST_IDLE;
    endcase
  end

  // Shared subtractor operands per state
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state)
      // rank > n! check
      perm_pkg::ST_CHECK: begin
        sub_a = fact_tbl[remaining];
        sub_b = perm_pkg::FACT_W'(k);
      end
      // zero-base the rank; borrow means rank was zero
      perm_pkg::ST_DEC: begin
        sub_a = perm_pkg::FACT_W'(k);
        sub_b = perm_pkg::FACT_W'(1);
      end
      // one quotient step against (remaining-1)!
      perm_pkg::ST_DIV: begin
        sub_a = perm_pkg::FACT_W'(k);
        sub_b = fact_tbl[CW'(remaining - CW'(1))];
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= perm_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Working registers and list of unused values
  always_ff @(posedge clk) begin
    unique case (state)
      perm_pkg::ST_IDLE: begin
        if (req_acc) begin
          k         <= req.rank;
          remaining <= CW'(req.set_size);
          idx       <= '0;
          for (int j = 0; j < MAX_SET; j++) pool[j] <= perm_pkg::ELEM_W'(j + 1);
        end
      end
      perm_pkg::ST_DEC: k <= sub_diff[perm_pkg::RANK_W-1:0];
      perm_pkg::ST_DIV: begin
        if (!sub_borrow) begin
          k   <= sub_diff[perm_pkg::RANK_W-1:0];
          idx <= idx + CW'(1);
        end
      end
      perm_pkg::ST_PICK: begin
        if (out_free) begin
          // close the gap left by the picked value
          for (int j = 0; j < MAX_SET - 1; j++) begin
            if (CW'(j) >= idx) pool[j] <= pool[j + 1];
          end
          remaining <= remaining - CW'(1);
          idx       <= '0;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == perm_pkg::ST_PICK || state == perm_pkg::ST_ERR) && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == perm_pkg::ST_PICK) begin
        out_elem <= pool[idx[IW-1:0]];
        out_last <= (remaining == CW'(1));
        out_err  <= 1'b0;
      end else if (state == perm_pkg::ST_ERR) begin
        out_elem <= '0;
        out_last <= 1'b1;
        out_err  <= 1'b1;
      end
    end
  end

  // Checks
  `PU_ASSERT_NOW(a_err_shape, clk, rst, res.valid && res.error, (res.element == '0) && res.last, "error result must carry element 0 and last")
  `PU_ASSERT_NOW(a_digit_range, clk, rst, (state == perm_pkg::ST_DIV) || (state == perm_pkg::ST_PICK), (remaining != '0) && (idx < remaining), "digit out of range of unused list")
  `PU_ASSERT_NXT(a_pick_emits, clk, rst, (state == perm_pkg::ST_PICK) && out_free, res.valid && !res.error, "picked element not presented")
  `PU_ASSERT_NOW(a_idle_on_err, clk, rst, (state == perm_pkg::ST_ERR) || (state == perm_pkg::ST_PICK), !req.ready, "request taken while busy")

endmodule
